[rtl/core/sorted_region_table_allocator_top_assert.svh]
// Assertion macros for the region table allocator top level.
// Plain text macros only; used by sorted_region_table_allocator_top.
`ifndef SORTED_REGION_TABLE_ALLOCATOR_TOP_ASSERT_SVH
`define SORTED_REGION_TABLE_ALLOCATOR_TOP_ASSERT_SVH

// same-cycle implication, checked out of reset
`define SRTA_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("srta implication check failed");

// next-cycle implication, checked out of reset
`define SRTA_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("srta next-cycle check failed");

`endif

[rtl/core/srta_pkg.sv]
// Shared types for the region table allocator.
// Command and status structs between controller and datapath; no dependencies.
package srta_pkg;

  typedef enum logic [1:0] {
    KIND_ADD   = 2'd0,
    KIND_ALLOC = 2'd1,
    KIND_MARK  = 2'd2,
    KIND_NONE  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_OVERLAP = 2'd2,
    ST_NOFIT   = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    IDX_HOLD,
    IDX_CLR,
    IDX_INC,
    IDX_DEC,
    IDX_CNT
  } idx_op_e;

  typedef enum logic [2:0] {
    WR_COPY,
    WR_ADD,
    WR_FRONT,
    WR_REST,
    WR_MARK
  } wr_src_e;

  localparam int unsigned AddrW = 48;
  localparam int unsigned SizeW = 49;
  localparam int unsigned FreeW = 50;
  localparam int unsigned TypeW = 4;
  localparam int unsigned InW   = 152;
  localparam int unsigned OutW  = 104;

  typedef struct packed {
    logic    load;
    idx_op_e idx_op;
    logic    rd_prev;
    logic    wr_en;
    wr_src_e wr_src;
    logic    wr_next;
    logic    pos_ld;
    logic    prev_ld;
    logic    prev_clr;
    logic    cnt_inc;
    logic    acc_clr;
    logic    acc_add;
    logic    st_ld;
    status_e st;
    logic    res_ld;
  } cmd_t;

  typedef struct packed {
    kind_e kind;
    logic  full;
    logic  size_zero;
    logic  at_count;
    logic  at_pos;
    logic  overlap;
    logic  after;
    logic  fit;
    logic  is_free;
    logic  out_free;
  } sts_t;

endpackage

[rtl/core/srta_dp.sv]
// Datapath of the region table allocator: table memory, counters,
// accumulator, config and result registers. Depends on srta_pkg.
module srta_dp #(
  parameter int unsigned Depth = 64
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic                            cfg_idx_i,
  input  logic [srta_pkg::TypeW-1:0]      cfg_wdata_i,
  input  logic [1:0]                      in_kind_i,
  input  logic [srta_pkg::AddrW-1:0]      in_start_i,
  input  logic [srta_pkg::AddrW-1:0]      in_end_i,
  input  logic [srta_pkg::TypeW-1:0]      in_type_i,
  input  logic [srta_pkg::SizeW-1:0]      in_size_i,
  input  srta_pkg::cmd_t                  cmd_i,
  output srta_pkg::sts_t                  sts_o,
  input  logic                            m_ready_i,
  output logic                            m_valid_o,
  output logic [srta_pkg::OutW-1:0]       m_data_o
);
  import srta_pkg::*;

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);

  logic [SizeW-1:0] mem_start [Depth];
  logic [AddrW-1:0] mem_end   [Depth];
  logic [TypeW-1:0] mem_type  [Depth];

  kind_e            kind_q;
  logic [AddrW-1:0] s_q, e_q, prev_end_q, fnd_end_q, rd_end_q;
  logic [TypeW-1:0] t_q, fnd_type_q, rd_type_q, free_code_q, pay_code_q;
  logic [SizeW-1:0] size_q, fnd_start_q, rd_start_q;
  logic [CW-1:0]    idx_q, pos_q, cnt_q, idx_m1, idx_p1;
  logic             prev_vld_q, m_valid_q;
  logic [FreeW-1:0] acc_q;
  status_e          st_q;
  logic [OutW-1:0]  m_data_q;

  logic [AW-1:0]    rd_addr, wr_addr;
  logic [SizeW-1:0] wr_start, rd_len;
  logic [AddrW-1:0] wr_end, res_addr;
  logic [TypeW-1:0] wr_type;
  logic [FreeW:0]   acc_sum;
  logic [FreeW-1:0] carve;

  assign idx_m1  = idx_q - 1'b1;
  assign idx_p1  = idx_q + 1'b1;
  assign rd_addr = cmd_i.rd_prev ? idx_m1[AW-1:0] : idx_q[AW-1:0];
  assign wr_addr = cmd_i.wr_next ? idx_p1[AW-1:0] : idx_q[AW-1:0];

  always_comb begin
    if ({1'b0, rd_end_q} >= rd_start_q) begin
      rd_len = {1'b0, rd_end_q} - rd_start_q + 1'b1;
    end else begin
      rd_len = '0;
    end
  end

  assign acc_sum = {1'b0, acc_q} + {2'b00, rd_len};
  assign carve   = {1'b0, fnd_start_q} + {1'b0, size_q};

  always_comb begin
    wr_start = rd_start_q;
    wr_end   = rd_end_q;
    wr_type  = rd_type_q;
    case (cmd_i.wr_src)
      WR_ADD: begin
        wr_start = {1'b0, s_q};
        wr_end   = e_q;
        wr_type  = t_q;
      end
      WR_FRONT: begin
        wr_start = fnd_start_q;
        wr_end   = AddrW'(carve - 1'b1);
        wr_type  = t_q;
      end
      WR_REST: begin
        wr_start = carve[SizeW-1:0];
        wr_end   = fnd_end_q;
        wr_type  = fnd_type_q;
      end
      WR_MARK: wr_type = pay_code_q;
      default: ;
    endcase
  end

  // two-port table: one registered read, one write per cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem_start[wr_addr] <= wr_start;
      mem_end[wr_addr]   <= wr_end;
      mem_type[wr_addr]  <= wr_type;
    end
    rd_start_q <= mem_start[rd_addr];
    rd_end_q   <= mem_end[rd_addr];
    rd_type_q  <= mem_type[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q <= kind_e'(in_kind_i);
      s_q    <= in_start_i;
      e_q    <= in_end_i;
      t_q    <= in_type_i;
      size_q <= in_size_i;
    end
    if (cmd_i.pos_ld) begin
      pos_q       <= idx_q;
      fnd_start_q <= rd_start_q;
      fnd_end_q   <= rd_end_q;
      fnd_type_q  <= rd_type_q;
    end
    if (cmd_i.prev_ld) prev_end_q <= rd_end_q;
    if (cmd_i.st_ld) st_q <= cmd_i.st;
    if (cmd_i.acc_clr) begin
      acc_q <= '0;
    end else if (cmd_i.acc_add && sts_o.is_free) begin
      acc_q <= acc_sum[FreeW] ? '1 : acc_sum[FreeW-1:0];
    end
    if (cmd_i.res_ld) m_data_q <= {4'b0000, acc_q, res_addr, st_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      idx_q       <= '0;
      prev_vld_q  <= 1'b0;
      m_valid_q   <= 1'b0;
      free_code_q <= 4'd0;
      pay_code_q  <= 4'd1;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i) pay_code_q <= cfg_wdata_i;
        else           free_code_q <= cfg_wdata_i;
      end
      case (cmd_i.idx_op)
        IDX_CLR: idx_q <= '0;
        IDX_INC: idx_q <= idx_p1;
        IDX_DEC: idx_q <= idx_m1;
        IDX_CNT: idx_q <= cnt_q;
        default: ;
      endcase
      if (cmd_i.prev_clr)     prev_vld_q <= 1'b0;
      else if (cmd_i.prev_ld) prev_vld_q <= 1'b1;
      if (cmd_i.cnt_inc) cnt_q <= cnt_q + 1'b1;
      if (cmd_i.res_ld)  m_valid_q <= 1'b1;
      else if (m_ready_i) m_valid_q <= 1'b0;
    end
  end

  assign res_addr = (kind_q == KIND_ALLOC && st_q == ST_OK) ? fnd_start_q[AddrW-1:0] : '0;

  always_comb begin
    sts_o.kind      = kind_q;
    sts_o.full      = cnt_q >= CW'(Depth);
    sts_o.size_zero = size_q == '0;
    sts_o.at_count  = idx_q == cnt_q;
    sts_o.at_pos    = idx_q == pos_q;
    sts_o.overlap   = prev_vld_q && (s_q <= prev_end_q);
    sts_o.after     = {1'b0, e_q} < rd_start_q;
    sts_o.is_free   = rd_type_q == free_code_q;
    sts_o.fit       = sts_o.is_free && (rd_len >= size_q);
    sts_o.out_free  = !m_valid_q || m_ready_i;
  end

  assign m_valid_o = m_valid_q;
  assign m_data_o  = m_data_q;
endmodule

[rtl/core/srta_ctrl.sv]
// Sequencer of the region table allocator: walks the table for add,
// allocate, mark and the free-byte recount. Depends on srta_pkg.
module srta_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           s_valid_i,
  output logic           s_ready_o,
  input  srta_pkg::sts_t sts_i,
  output srta_pkg::cmd_t cmd_o
);
  import srta_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DISP, S_ADD_PT, S_ADD_CMP, S_ALC_RD, S_ALC_CMP, S_SH_CHK, S_SH_WR,
    S_WR_NEW, S_WR_FRONT, S_MRK_RD, S_MRK_WR, S_SUM_START, S_SUM_RD, S_SUM_ACC, S_DONE
  } state_e;

  state_e state_q, state_d;

  assign s_ready_o = state_q == S_IDLE;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.st = ST_OK;
    unique case (state_q)
      S_IDLE: if (s_valid_i) begin
        cmd_o.load = 1'b1;
        state_d    = S_DISP;
      end
      S_DISP: begin
        cmd_o.st_ld    = 1'b1;
        cmd_o.prev_clr = 1'b1;
        cmd_o.idx_op   = IDX_CLR;
        unique case (sts_i.kind)
          KIND_ADD: begin
            if (sts_i.full) begin
              cmd_o.st = ST_FULL;
              state_d  = S_SUM_START;
            end else begin
              state_d  = S_ADD_PT;
            end
          end
          KIND_ALLOC: begin
            if (sts_i.full) begin
              cmd_o.st = ST_FULL;
              state_d  = S_SUM_START;
            end else if (sts_i.size_zero) begin
              cmd_o.st = ST_NOFIT;
              state_d  = S_SUM_START;
            end else begin
              state_d  = S_ALC_RD;
            end
          end
          KIND_MARK: state_d = S_MRK_RD;
          default:   state_d = S_SUM_START;
        endcase
      end
      S_ADD_PT: begin
        if (sts_i.overlap) begin
          cmd_o.st_ld = 1'b1;
          cmd_o.st    = ST_OVERLAP;
          state_d     = S_SUM_START;
        end else if (sts_i.at_count) begin
          cmd_o.pos_ld = 1'b1;
          cmd_o.idx_op = IDX_CNT;
          state_d      = S_SH_CHK;
        end else begin
          state_d      = S_ADD_CMP;
        end
      end
      S_ADD_CMP: begin
        if (sts_i.after) begin
          cmd_o.pos_ld = 1'b1;
          cmd_o.idx_op = IDX_CNT;
          state_d      = S_SH_CHK;
        end else begin
          cmd_o.prev_ld = 1'b1;
          cmd_o.idx_op  = IDX_INC;
          state_d       = S_ADD_PT;
        end
      end
      S_ALC_RD: begin
        if (sts_i.at_count) begin
          cmd_o.st_ld = 1'b1;
          cmd_o.st    = ST_NOFIT;
          state_d     = S_SUM_START;
        end else begin
          state_d     = S_ALC_CMP;
        end
      end
      S_ALC_CMP: begin
        if (sts_i.fit) begin
          cmd_o.pos_ld = 1'b1;
          cmd_o.idx_op = IDX_CNT;
          state_d      = S_SH_CHK;
        end else begin
          cmd_o.idx_op = IDX_INC;
          state_d      = S_ALC_RD;
        end
      end
      // open a slot: move entries up from the top, one entry per pass through S_SH_CHK and S_SH_WR
      S_SH_CHK: begin
        if (sts_i.at_pos) begin
          state_d = S_WR_NEW;
        end else begin
          cmd_o.rd_prev = 1'b1;
          state_d       = S_SH_WR;
        end
      end
      S_SH_WR: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_src = WR_COPY;
        cmd_o.idx_op = IDX_DEC;
        state_d      = S_SH_CHK;
      end
      S_WR_NEW: begin
        cmd_o.wr_en = 1'b1;
        if (sts_i.kind == KIND_ADD) begin
          cmd_o.wr_src  = WR_ADD;
          cmd_o.cnt_inc = 1'b1;
          state_d       = S_SUM_START;
        end else begin
          cmd_o.wr_src  = WR_REST;
          cmd_o.wr_next = 1'b1;
          state_d       = S_WR_FRONT;
        end
      end
      S_WR_FRONT: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_src  = WR_FRONT;
        cmd_o.cnt_inc = 1'b1;
        state_d       = S_SUM_START;
      end
      S_MRK_RD: state_d = sts_i.at_count ? S_SUM_START : S_MRK_WR;
      S_MRK_WR: begin
        cmd_o.wr_en  = sts_i.is_free;
        cmd_o.wr_src = WR_MARK;
        cmd_o.idx_op = IDX_INC;
        state_d      = S_MRK_RD;
      end
      S_SUM_START: begin
        cmd_o.idx_op  = IDX_CLR;
        cmd_o.acc_clr = 1'b1;
        state_d       = S_SUM_RD;
      end
      S_SUM_RD: state_d = sts_i.at_count ? S_DONE : S_SUM_ACC;
      S_SUM_ACC: begin
        cmd_o.acc_add = 1'b1;
        cmd_o.idx_op  = IDX_INC;
        state_d       = S_SUM_RD;
      end
      S_DONE: if (sts_i.out_free) begin
        cmd_o.res_ld = 1'b1;
        state_d      = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end
endmodule

[rtl/core/sorted_region_table_allocator_top.sv]
// Region table allocator: keeps address-sorted regions, adds, first-fit
// allocates and retypes free regions, reporting the free-byte total after
// every transaction. One transaction is worked at a time. Every table
// access, the slot shift and the free-byte recount go through the one
// read port and one write port of the table memory. A result waits in an
// output register, so the next transaction is taken while it is still
// pending; a result held back by the sink stalls the following one at its
// final cycle.
// Depends on srta_pkg, srta_ctrl, srta_dp and the assertion macro header.
module sorted_region_table_allocator_top #(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic                       cfg_idx_i,
  input  logic [3:0]                 cfg_wdata_i,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  // region_start, region_end, region_type, alloc_size (low to high), zero pad
  input  logic [srta_pkg::InW-1:0]   s_axis_tdata,
  // kind
  input  logic [1:0]                 s_axis_tuser,
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // status, alloc_address, free_bytes (low to high), zero pad
  output logic [srta_pkg::OutW-1:0]  m_axis_tdata
);
  import srta_pkg::*;

  `include "sorted_region_table_allocator_top_assert.svh"

  cmd_t cmd;
  sts_t sts;

  srta_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  srta_dp #(
    .Depth (TABLE_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_kind_i   (s_axis_tuser),
    .in_start_i  (s_axis_tdata[47:0]),
    .in_end_i    (s_axis_tdata[95:48]),
    .in_type_i   (s_axis_tdata[99:96]),
    .in_size_i   (s_axis_tdata[148:100]),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .m_ready_i   (m_axis_tready),
    .m_valid_o   (m_axis_tvalid),
    .m_data_o    (m_axis_tdata)
  );

  // no table write while waiting for a transaction
  `SRTA_ASSERT_IMP(a_idle_no_write, clk_i, rst_ni, s_axis_tready, !cmd.wr_en)
  // a loaded result is offered on the next cycle
  `SRTA_ASSERT_NXT(a_result_shown, clk_i, rst_ni, cmd.res_ld, m_axis_tvalid)
  // failed transactions never report an allocation address
  `SRTA_ASSERT_IMP(a_fail_no_addr, clk_i, rst_ni,
                   m_axis_tvalid && m_axis_tdata[1:0] != ST_OK, m_axis_tdata[49:2] == '0)
endmodule
